FILE: design/pjq_pkg.sv
package pjq_pkg;

	// Operation codes carried in the request.
	localparam logic [1:0] FUNC_ADD    = 2'd0;
	localparam logic [1:0] FUNC_PROC   = 2'd1;
	localparam logic [1:0] FUNC_CANCEL = 2'd2;
	localparam logic [1:0] FUNC_DISP   = 2'd3;

	// Result status codes.
	localparam logic [1:0] STAT_ENTRY = 2'd0;
	localparam logic [1:0] STAT_BLANK = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;

	// Priority character that sends a job to the head of the queue.
	localparam logic [7:0] URGENT_CHAR = 8'h55;

	// Kinds of result the controller can ask the datapath to produce.
	localparam logic [1:0] EMIT_NONE  = 2'd0;
	localparam logic [1:0] EMIT_ENTRY = 2'd1;
	localparam logic [1:0] EMIT_BLANK = 2'd2;
	localparam logic [1:0] EMIT_FULL  = 2'd3;

	typedef struct packed {
		logic [1:0]  func;
		logic [15:0] job_id;
		logic [15:0] pages;
		logic [7:0]  priority_char;
		logic        reverse_order;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] out_job_id;
		logic [15:0] out_pages;
		logic [7:0]  out_priority;
		logic        last;
	} res_t;

	typedef struct packed {
		logic [15:0] id;
		logic [15:0] pages;
		logic [7:0]  prio;
	} entry_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       load_req;
		logic       rd_en;
		logic       start_shift;
		logic       wr_shift;
		logic       add_entry;
		logic       pop_head;
		logic       dec_count;
		logic [1:0] emit;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic cnt_zero;
		logic full;
		logic idx_lt_cnt;
		logic vld;
		logic hit;
		logic at_end;
		logic scan_done;
	} stat_t;

endpackage

FILE: design/pjq_ctrl.sv
module pjq_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [1:0]           func,
	input  pjq_pkg::stat_t       stat,
	output pjq_pkg::cmd_t        cmd,
	output logic                 busy
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SCAN  = 3'd1;
	localparam logic [2:0] S_SHIFT = 3'd2;
	localparam logic [2:0] S_PRD   = 3'd3;
	localparam logic [2:0] S_PWAIT = 3'd4;
	localparam logic [2:0] S_DISP  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic [1:0] op_q;

	// State and operation registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= pjq_pkg::FUNC_ADD;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE && start) begin
				op_q <= func;
			end
		end
	end

	assign busy = (state_q != S_IDLE);

	// Next state and command decode.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.emit = pjq_pkg::EMIT_NONE;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load_req = 1'b1;
					case (func)
						pjq_pkg::FUNC_ADD,
						pjq_pkg::FUNC_CANCEL: begin
							state_d = S_SCAN;
						end
						pjq_pkg::FUNC_PROC: begin
							if (stat.cnt_zero) cmd.emit = pjq_pkg::EMIT_BLANK;
							else state_d = S_PRD;
						end
						default: begin
							if (stat.cnt_zero) cmd.emit = pjq_pkg::EMIT_BLANK;
							else state_d = S_DISP;
						end
					endcase
				end
			end
			S_SCAN: begin
				cmd.rd_en = stat.idx_lt_cnt & ~stat.hit;
				if (stat.hit) begin
					if (op_q == pjq_pkg::FUNC_ADD) begin
						cmd.emit = pjq_pkg::EMIT_BLANK;
						state_d  = S_IDLE;
					end else begin
						cmd.emit = pjq_pkg::EMIT_ENTRY;
						if (stat.at_end) begin
							cmd.dec_count = 1'b1;
							state_d       = S_IDLE;
						end else begin
							cmd.start_shift = 1'b1;
							state_d         = S_SHIFT;
						end
					end
				end else if (stat.scan_done) begin
					state_d = S_IDLE;
					if (op_q == pjq_pkg::FUNC_ADD) begin
						if (stat.full) cmd.emit = pjq_pkg::EMIT_FULL;
						else cmd.add_entry = 1'b1;
					end else begin
						cmd.emit = pjq_pkg::EMIT_BLANK;
					end
				end
			end
			S_SHIFT: begin
				cmd.rd_en    = stat.idx_lt_cnt;
				cmd.wr_shift = stat.vld;
				if (stat.at_end) begin
					cmd.dec_count = 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_PRD: begin
				cmd.rd_en = 1'b1;
				state_d   = S_PWAIT;
			end
			S_PWAIT: begin
				cmd.emit     = pjq_pkg::EMIT_ENTRY;
				cmd.pop_head = 1'b1;
				state_d      = S_IDLE;
			end
			S_DISP: begin
				cmd.rd_en = stat.idx_lt_cnt;
				if (stat.vld) cmd.emit = pjq_pkg::EMIT_ENTRY;
				if (stat.at_end) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

FILE: design/pjq_dp.sv
module pjq_dp #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  pjq_pkg::req_t   request,
	input  pjq_pkg::cmd_t   cmd,
	output pjq_pkg::stat_t  stat,
	output logic            result_valid,
	output pjq_pkg::res_t   result
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	pjq_pkg::entry_t mem [QUEUE_DEPTH];

	pjq_pkg::req_t   req_q;
	logic [AW-1:0]   head_q;
	logic [CW-1:0]   cnt_q;
	logic [CW-1:0]   idx_q;
	logic [CW-1:0]   idx_s1;
	logic            vld_s1;
	pjq_pkg::entry_t rd_data_s1;
	logic            result_valid_q;
	pjq_pkg::res_t   result_q;

	logic [CW-1:0]   rd_log;
	logic [AW-1:0]   rd_addr;
	logic [AW-1:0]   head_dec;
	logic [AW-1:0]   head_inc;
	logic            urgent;
	logic            mem_we;
	logic [AW-1:0]   wr_addr;
	pjq_pkg::entry_t wr_data;
	pjq_pkg::entry_t new_entry;

	// Map a queue position (0 is the head) to a physical slot of the ring.
	function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [CW-1:0] pos);
		logic [CW:0] sum;
		sum = (CW+1)'(head) + (CW+1)'(pos);
		if (sum >= (CW+1)'(QUEUE_DEPTH)) begin
			sum = sum - (CW+1)'(QUEUE_DEPTH);
		end
		return AW'(sum);
	endfunction

	// Read position: reverse display walks from the tail.
	always_comb begin
		if (req_q.func == pjq_pkg::FUNC_DISP && req_q.reverse_order) begin
			rd_log = cnt_q - CW'(1) - idx_q;
		end else begin
			rd_log = idx_q;
		end
		rd_addr = phys(head_q, rd_log);
	end

	assign head_dec  = (head_q == '0) ? AW'(QUEUE_DEPTH - 1) : head_q - AW'(1);
	assign head_inc  = (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + AW'(1);
	assign urgent    = (req_q.priority_char == pjq_pkg::URGENT_CHAR);
	assign new_entry = '{id: req_q.job_id, pages: req_q.pages, prio: req_q.priority_char};

	// Write port: a new job at the head or tail, or one step of a cancel shift.
	always_comb begin
		mem_we  = cmd.add_entry | cmd.wr_shift;
		wr_data = cmd.wr_shift ? rd_data_s1 : new_entry;
		if (cmd.wr_shift) begin
			wr_addr = phys(head_q, idx_s1 - CW'(1));
		end else if (urgent) begin
			wr_addr = head_dec;
		end else begin
			wr_addr = phys(head_q, cnt_q);
		end
	end

	// Entry memory with a registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	// Request register and read position tags.
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q <= request;
		end
		idx_s1 <= idx_q;
	end

	// Queue pointers, walk counter and read valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			cnt_q  <= '0;
			idx_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= cmd.rd_en;
			if (cmd.load_req) begin
				idx_q <= '0;
			end else if (cmd.start_shift) begin
				idx_q <= idx_s1 + CW'(1);
			end else if (cmd.rd_en) begin
				idx_q <= idx_q + CW'(1);
			end
			if (cmd.add_entry) begin
				cnt_q <= cnt_q + CW'(1);
				if (urgent) head_q <= head_dec;
			end else if (cmd.pop_head) begin
				cnt_q  <= cnt_q - CW'(1);
				head_q <= head_inc;
			end else if (cmd.dec_count) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	// Status toward the controller.
	always_comb begin
		stat.cnt_zero   = (cnt_q == '0);
		stat.full       = (cnt_q == CW'(QUEUE_DEPTH));
		stat.idx_lt_cnt = (idx_q < cnt_q);
		stat.vld        = vld_s1;
		stat.hit        = vld_s1 && (rd_data_s1.id == req_q.job_id);
		stat.at_end     = vld_s1 && (idx_s1 == cnt_q - CW'(1));
		stat.scan_done  = stat.cnt_zero | stat.at_end;
	end

	// Result register; blank and full results carry zero fields.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= (cmd.emit != pjq_pkg::EMIT_NONE);
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.emit)
			pjq_pkg::EMIT_ENTRY: begin
				result_q.status       <= pjq_pkg::STAT_ENTRY;
				result_q.out_job_id   <= rd_data_s1.id;
				result_q.out_pages    <= rd_data_s1.pages;
				result_q.out_priority <= rd_data_s1.prio;
				result_q.last         <= (req_q.func != pjq_pkg::FUNC_DISP) | stat.at_end;
			end
			pjq_pkg::EMIT_BLANK: begin
				result_q <= '{status: pjq_pkg::STAT_BLANK, out_job_id: '0,
					out_pages: '0, out_priority: '0, last: 1'b1};
			end
			pjq_pkg::EMIT_FULL: begin
				result_q <= '{status: pjq_pkg::STAT_FULL, out_job_id: '0,
					out_pages: '0, out_priority: '0, last: 1'b1};
			end
			default: begin
				result_q <= result_q;
			end
		endcase
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// The job count never passes the queue depth.
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= CW'(QUEUE_DEPTH))
		else $error("job count above queue depth");

	// A job is only added to a queue that has room.
	assert property (@(posedge clk) disable iff (!arst_n) cmd.add_entry |-> !stat.full)
		else $error("add into a full queue");

	// A job is only removed from a queue that holds one.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.pop_head || cmd.dec_count) |-> !stat.cnt_zero)
		else $error("removal from an empty queue");

	// Blank and full results always close their request.
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && result_q.status != pjq_pkg::STAT_ENTRY) |-> result_q.last)
		else $error("blank or full result without last");

endmodule

FILE: design/print_job_queue_with_cancel.sv
// Job queue with urgent insertion at the head, pop from the head, cancel by id and display.
// Add walks the entry memory for a duplicate id, one read a cycle; process reads and pops the
// head entry; cancel walks to the job by id, then shifts the later entries one slot toward the
// head when the job was not the tail; display gives the entries in order, or from the tail when
// reverse_order is set. Reset clears the job count and head pointer, not the entry memory.
// Results appear for one cycle on result_valid; the receiver cannot stall them.
module print_job_queue_with_cancel #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  pjq_pkg::req_t request,
	output logic          busy,
	output logic          result_valid,
	output pjq_pkg::res_t result
);

	pjq_pkg::cmd_t  cmd;
	pjq_pkg::stat_t stat;

	// Sequencer for the request walks.
	pjq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (request.func),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// Entry memory, ring pointers and result register.
	pjq_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.request      (request),
		.cmd          (cmd),
		.stat         (stat),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule
